/* sv/fcbd_pkg.sv */
// ----------------------------------------------------------------------------
// fcbd_pkg
// Shared constants and controller/datapath interface types for the codeword
// bit deinterleaver.
// ----------------------------------------------------------------------------
package fcbd_pkg;

    localparam int NUM_SEGS   = 40;
    localparam int CW_W       = 40;
    localparam int SEG_W      = 6;
    localparam int CH_W       = 11;
    localparam int BYTE_NUM_W = 10;
    localparam int OUT_W      = 24;

    localparam logic [SEG_W-1:0] LAST_SEG = SEG_W'(NUM_SEGS - 1);

    // controller -> datapath
    typedef struct packed {
        logic shift_in;   // accepted codeword enters the transpose store
        logic load;       // eighth codeword: copy store into burst buffer
        logic shift_out;  // burst byte taken, advance buffer
    } fcbd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic word_last;  // next codeword closes the group
    } fcbd_stat_t;

endpackage

/* sv/fec_codeword_bit_deinterleaver.sv */
// ----------------------------------------------------------------------------
// fec_codeword_bit_deinterleaver
// 8 x 40 bit transpose of 40-bit FEC codewords into segment bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one 40-bit codeword per item. Every eighth codeword
//   closes a group; the group is then sent on the m_ channel as 40 items,
//   segments 0..39, each with its segment index, byte index (group number
//   in the block) and the transposed byte. m_tlast marks segment 39 of each
//   burst, m_tuser marks the last byte of the whole block.
//   cfg_ channel writes column_height (groups per block); write it only
//   while the block is idle.
// Bursts: the first byte of a burst is valid in the cycle after the eighth
//   codeword is accepted; each burst carries the 40 segment bytes of a group.
//   The eighth codeword of a group waits until the burst buffer has drained;
//   codewords 1-7 of the next group are taken during a burst.
// Reset: counters cleared, column_height = 1. A stalled receiver holds the
//   current byte; input keeps filling the store until the group is full.
// ----------------------------------------------------------------------------
module fec_codeword_bit_deinterleaver #(
    parameter int MAX_COLUMN_HEIGHT = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [39:0] codeword
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [5:0] segment_index, [15:6] byte_index,
                                   // [23:16] segment_byte
    output logic        m_tlast,   // burst_last
    output logic        m_tuser,   // [0] block_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data   // column_height
);
    import fcbd_pkg::*;

    fcbd_cmd_t             cmd;
    fcbd_stat_t            stat;
    logic [SEG_W-1:0]      seg;
    logic [BYTE_NUM_W-1:0] byte_index;
    logic [7:0]            segment_byte;
    logic                  block_last;

    assign cfg_ready = 1'b1;

    fcbd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd),
        .seg      (seg)
    );

    fcbd_datapath #(
        .MAX_COLUMN_HEIGHT (MAX_COLUMN_HEIGHT)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .codeword     (s_tdata),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .byte_index   (byte_index),
        .segment_byte (segment_byte),
        .block_last   (block_last)
    );

    assign m_tdata = {segment_byte, byte_index, seg};
    assign m_tlast = (seg == LAST_SEG);
    assign m_tuser = m_tlast && block_last;

endmodule

/* sv/fcbd_ctrl.sv */
// ----------------------------------------------------------------------------
// fcbd_ctrl
// Handshake control: collects codewords, runs the 40-byte output burst and
// tracks the segment under output.
// ----------------------------------------------------------------------------
module fcbd_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    input  fcbd_pkg::fcbd_stat_t     stat,
    output fcbd_pkg::fcbd_cmd_t      cmd,
    output logic [fcbd_pkg::SEG_W-1:0] seg
);
    import fcbd_pkg::*;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_BURST = 1'b1;

    logic             state_reg, state_next;
    logic [SEG_W-1:0] seg_reg, seg_next;
    logic             in_acc, out_acc;

    // the closing codeword waits until the burst buffer is free
    assign s_tready = (state_reg == ST_IDLE) || !stat.word_last;
    assign m_tvalid = (state_reg == ST_BURST);
    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;

    assign cmd.shift_in  = in_acc;
    assign cmd.load      = in_acc && stat.word_last;
    assign cmd.shift_out = out_acc;
    assign seg           = seg_reg;

    always_comb begin
        state_next = state_reg;
        seg_next   = seg_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && stat.word_last) begin
                    state_next = ST_BURST;
                    seg_next   = '0;
                end
            end
            ST_BURST: begin
                if (out_acc) begin
                    seg_next = seg_reg + SEG_W'(1);
                    if (seg_reg == LAST_SEG) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            seg_reg   <= '0;
        end else begin
            state_reg <= state_next;
            seg_reg   <= seg_next;
        end
    end

endmodule

/* sv/fcbd_datapath.sv */
// ----------------------------------------------------------------------------
// fcbd_datapath
// Transpose store, burst buffer, group counter and height register.
// ----------------------------------------------------------------------------
module fcbd_datapath #(
    parameter int MAX_COLUMN_HEIGHT = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [fcbd_pkg::CW_W-1:0]     codeword,
    input  logic                          cfg_we,
    input  logic [fcbd_pkg::CH_W-1:0]     cfg_data,
    input  fcbd_pkg::fcbd_cmd_t           cmd,
    output fcbd_pkg::fcbd_stat_t          stat,
    output logic [fcbd_pkg::BYTE_NUM_W-1:0] byte_index,
    output logic [7:0]                    segment_byte,
    output logic                          block_last
);
    import fcbd_pkg::*;

    localparam int GW   = (MAX_COLUMN_HEIGHT > 1) ? $clog2(MAX_COLUMN_HEIGHT) : 1;
    localparam int CMPW = ((GW + 1) > CH_W) ? (GW + 1) : CH_W;
    localparam logic [CMPW-1:0] MAX_H = CMPW'(MAX_COLUMN_HEIGHT);

    logic [7:0]      store_reg [NUM_SEGS];
    logic [7:0]      store_next [NUM_SEGS];
    logic [7:0]      burst_reg [NUM_SEGS];
    logic [2:0]      word_reg;
    logic [GW-1:0]   group_reg;
    logic [CH_W-1:0] height_reg;
    logic [BYTE_NUM_W-1:0] bidx_reg;
    logic            blast_reg;
    logic [CMPW-1:0] col_ext, eff_h, grp_inc;
    logic            last_group;

    assign stat.word_last = (word_reg == 3'd7);

    // segment j takes codeword bit 39-j; earliest codeword ends in the MSB
    always_comb begin
        for (int j = 0; j < NUM_SEGS; j++) begin
            store_next[j] = {store_reg[j][6:0], codeword[CW_W-1-j]};
        end
    end

    // zero acts as one, anything above the maximum as the maximum
    always_comb begin
        col_ext = CMPW'(height_reg);
        if (col_ext == '0) begin
            eff_h = CMPW'(1);
        end else if (col_ext > MAX_H) begin
            eff_h = MAX_H;
        end else begin
            eff_h = col_ext;
        end
        grp_inc    = CMPW'(group_reg) + CMPW'(1);
        last_group = (grp_inc >= eff_h);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg   <= '0;
            group_reg  <= '0;
            height_reg <= CH_W'(1);
        end else begin
            if (cfg_we) begin
                height_reg <= cfg_data;
            end
            if (cmd.shift_in) begin
                word_reg <= word_reg + 3'd1;
            end
            if (cmd.load) begin
                group_reg <= last_group ? '0 : group_reg + GW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.shift_in) begin
            for (int j = 0; j < NUM_SEGS; j++) begin
                store_reg[j] <= store_next[j];
            end
        end
        if (cmd.load) begin
            for (int j = 0; j < NUM_SEGS; j++) begin
                burst_reg[j] <= store_next[j];
            end
            bidx_reg  <= BYTE_NUM_W'(group_reg);
            blast_reg <= last_group;
        end else if (cmd.shift_out) begin
            for (int j = 0; j < NUM_SEGS - 1; j++) begin
                burst_reg[j] <= burst_reg[j+1];
            end
        end
    end

    assign segment_byte = burst_reg[0];
    assign byte_index   = bidx_reg;
    assign block_last   = blast_reg;

endmodule
